// ===== rtl/core/tccs_pkg.sv =====
// ----------------------------------------------------------------------------
// tccs_pkg: shared types and constants of the text console cursor/scroll unit
// Request codes, control characters, field widths and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package tccs_pkg;

   // Fixed widths of the request and result fields.
   localparam int TYPE_W = 2;
   localparam int CHAR_W = 8;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int CELL_W = 2 * CHAR_W;

   // Request codes.
   localparam logic [TYPE_W-1:0] REQ_PUT   = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_READ  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd2;

   // Control characters and the attribute register's reset value.
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
   localparam logic [CHAR_W-1:0] ATTR_RESET = 8'h0F;

   // One result record.
   typedef struct packed {
      logic [CHAR_W-1:0] cell_char;
      logic [CHAR_W-1:0] cell_attr;
      logic [ROW_W-1:0]  cursor_row;
      logic [COL_W-1:0]  cursor_col;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/tccs_ram.sv =====
// ----------------------------------------------------------------------------
// tccs_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tccs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/tccs_seq.sv =====
// ----------------------------------------------------------------------------
// tccs_seq: screen store sequencer
// Holds the cursor and the screen RAM and runs the put, read, clear and
// scroll operations on it, including the clearing sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tccs_seq #(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [tccs_pkg::TYPE_W-1:0] req_type,
   input  wire logic [tccs_pkg::CHAR_W-1:0] req_char_code,
   input  wire logic [tccs_pkg::ROW_W-1:0]  req_read_row,
   input  wire logic [tccs_pkg::COL_W-1:0]  req_read_col,
   input  wire logic [tccs_pkg::CHAR_W-1:0] text_attribute,
   output logic                             res_valid,
   input  wire logic                        res_take,
   output tccs_pkg::rsp_type                res
);

   localparam int CELLS = ROWS * COLS;
   localparam int MOVE  = (ROWS - 1) * COLS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(CELLS + 1);
   localparam int RW    = $clog2(ROWS + 1);
   localparam int CLW   = $clog2(COLS);

   typedef enum logic [6:0] {
      S_INIT  = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_PUT   = 7'b0000100,
      S_SHIFT = 7'b0001000,
      S_CLEAR = 7'b0010000,
      S_READ  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type                     state_ff, state_in;
   logic [CW-1:0]                 idx_ff, idx_in;
   logic [CW-1:0]                 wr_idx;
   logic [RW-1:0]                 row_ff, row_in;
   logic [CLW-1:0]                col_ff, col_in;
   logic [tccs_pkg::CHAR_W-1:0]   char_ff, char_in;
   logic [tccs_pkg::CHAR_W-1:0]   rchar_ff, rchar_in;
   logic [tccs_pkg::CHAR_W-1:0]   rattr_ff, rattr_in;
   logic [tccs_pkg::CHAR_W-1:0]   put_ch;
   logic [AW-1:0]                 put_addr;
   logic                          do_put;
   logic                          read_in_range;
   logic                          mem_we;
   logic [AW-1:0]                 mem_waddr;
   logic [tccs_pkg::CELL_W-1:0]   mem_wdata;
   logic                          mem_re;
   logic [AW-1:0]                 mem_raddr;
   logic [tccs_pkg::CELL_W-1:0]   mem_rdata;

   // Screen store: character in the low byte, attribute in the high byte.
   tccs_ram #(
      .WIDTH (tccs_pkg::CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Operands of the put step and of a cell read.
   assign put_ch        = (state_ff == S_PUT) ? char_ff : req_char_code;
   assign put_addr      = AW'(32'(row_ff) * COLS + 32'(col_ff));
   assign read_in_range = (32'(req_read_row) < ROWS) && (32'(req_read_col) < COLS);
   assign wr_idx        = idx_ff - CW'(1);

   // Sequencer. During a scroll the source cell a is read at step a - COLS
   // and written as a destination only at step a + 1, so a read never meets
   // a pending write of the same entry.
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      char_in   = char_ff;
      rchar_in  = rchar_ff;
      rattr_in  = rattr_ff;
      do_put    = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      mem_re    = 1'b0;
      mem_raddr = '0;

      case (state_ff)
         S_INIT, S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff[AW-1:0];
            if (idx_ff == CW'(CELLS - 1)) begin
               idx_in   = '0;
               state_in = (state_ff == S_INIT) ? S_IDLE : S_DONE;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               rchar_in = '0;
               rattr_in = '0;
               case (req_type)
                  tccs_pkg::REQ_PUT: begin
                     if (row_ff == RW'(ROWS)) begin
                        char_in  = req_char_code;
                        idx_in   = '0;
                        state_in = S_SHIFT;
                     end else begin
                        do_put   = 1'b1;
                        state_in = S_DONE;
                     end
                  end
                  tccs_pkg::REQ_READ: begin
                     if (read_in_range) begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(32'(req_read_row) * COLS + 32'(req_read_col));
                        state_in  = S_READ;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  tccs_pkg::REQ_CLEAR: begin
                     idx_in   = '0;
                     state_in = S_CLEAR;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_SHIFT: begin
            if (idx_ff < CW'(MOVE)) begin
               mem_re    = 1'b1;
               mem_raddr = AW'(32'(idx_ff) + COLS);
            end
            if (idx_ff != '0) begin
               mem_we    = 1'b1;
               mem_waddr = wr_idx[AW-1:0];
               mem_wdata = (wr_idx < CW'(MOVE)) ? mem_rdata : '0;
            end
            if (idx_ff == CW'(CELLS)) begin
               idx_in   = '0;
               row_in   = RW'(ROWS - 1);
               state_in = S_PUT;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         S_PUT: begin
            do_put   = 1'b1;
            state_in = S_DONE;
         end
         S_READ: begin
            rchar_in = mem_rdata[tccs_pkg::CHAR_W-1:0];
            rattr_in = mem_rdata[tccs_pkg::CELL_W-1:tccs_pkg::CHAR_W];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Put step: control characters move the cursor, others are stored.
      if (do_put) begin
         if (put_ch == tccs_pkg::CH_NEWLINE) begin
            row_in = row_ff + RW'(1);
            col_in = '0;
         end else if (put_ch == tccs_pkg::CH_RETURN) begin
            col_in = '0;
         end else begin
            mem_we    = 1'b1;
            mem_waddr = put_addr;
            mem_wdata = {text_attribute, put_ch};
            if (col_ff == CLW'(COLS - 1)) begin
               row_in = row_ff + RW'(1);
               col_in = '0;
            end else begin
               col_in = col_ff + CLW'(1);
            end
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         idx_ff   <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      char_ff  <= char_in;
      rchar_ff <= rchar_in;
      rattr_ff <= rattr_in;
   end

   // Handshake and result.
   assign req_ready      = (state_ff == S_IDLE);
   assign res_valid      = (state_ff == S_DONE);
   assign res.cell_char  = rchar_ff;
   assign res.cell_attr  = rattr_ff;
   assign res.cursor_row = tccs_pkg::ROW_W'(row_ff);
   assign res.cursor_col = tccs_pkg::COL_W'(col_ff);

   // The walk counter never runs more than one past the last entry of the store.
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= CW'(CELLS))
      else $error("walk counter beyond the screen store");

   // The cursor stays on the screen, with the row at most one past the end.
   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      (row_ff <= RW'(ROWS)) && (col_ff <= CLW'(COLS - 1)))
      else $error("cursor off the screen");

   // A finished scroll leaves the cursor on the last row before the put.
   a_scroll_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT && state_in == S_PUT) |=> (row_ff == RW'(ROWS - 1)))
      else $error("scroll did not step the row back");

   // A pending scroll is always resolved before a put writes a cell.
   a_put_row: assert property (@(posedge clock) disable iff (reset)
      (do_put && mem_we) |-> (row_ff < RW'(ROWS)))
      else $error("put wrote a cell past the last row");

endmodule

`default_nettype wire

// ===== rtl/core/text_console_cursor_scroll_unit.sv =====
// Flow: a put, an out-of-range read or an unused request passes from the idle
// state straight to the done state, an in-range read through the read state
// and a clear through the clear sweep; a put with a pending scroll first walks
// the screen RAM and then does the put step. The sequencer takes a new request
// only once its result has moved on into the result register. After reset the
// unit sweeps the RAM to zero before it takes a request; csr is open.
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_unit: text console with cursor and scrolling
// Top level: attribute register, screen sequencer and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_scroll_unit #(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // Request channel.
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [tccs_pkg::TYPE_W-1:0] req_type,
   input  wire logic [tccs_pkg::CHAR_W-1:0] req_char_code,
   input  wire logic [tccs_pkg::ROW_W-1:0]  req_read_row,
   input  wire logic [tccs_pkg::COL_W-1:0]  req_read_col,
   // Result channel.
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [tccs_pkg::CHAR_W-1:0]      rsp_cell_char,
   output logic [tccs_pkg::CHAR_W-1:0]      rsp_cell_attr,
   output logic [tccs_pkg::ROW_W-1:0]       rsp_cursor_row,
   output logic [tccs_pkg::COL_W-1:0]       rsp_cursor_col,
   // Configuration channel.
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [tccs_pkg::CHAR_W-1:0] csr_text_attribute
);

   logic [tccs_pkg::CHAR_W-1:0] attr_ff, attr_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   tccs_pkg::rsp_type           rsp_ff, rsp_in;
   tccs_pkg::rsp_type           res;
   logic                        res_valid;
   logic                        res_take;

   // Attribute register, written by a configuration transfer.
   assign csr_ready = 1'b1;
   assign attr_in   = (csr_valid && csr_ready) ? csr_text_attribute : attr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= tccs_pkg::ATTR_RESET;
      end else begin
         attr_ff <= attr_in;
      end
   end

   tccs_seq #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_char_code  (req_char_code),
      .req_read_row   (req_read_row),
      .req_read_col   (req_read_col),
      .text_attribute (attr_ff),
      .res_valid      (res_valid),
      .res_take       (res_take),
      .res            (res)
   );

   // Result register: takes a finished result whenever it is empty or drains.
   assign res_take     = res_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = res_take || (rsp_valid_ff && !rsp_ready);
   assign rsp_in       = res_take ? res : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_char  = rsp_ff.cell_char;
   assign rsp_cell_attr  = rsp_ff.cell_attr;
   assign rsp_cursor_row = rsp_ff.cursor_row;
   assign rsp_cursor_col = rsp_ff.cursor_col;

endmodule

`default_nettype wire

// ===== tb/tb_text_console_cursor_scroll_unit.sv =====
// ----------------------------------------------------------------------------
// tb_text_console_cursor_scroll_unit: self-checking bench of the text console
// Drives put, read, clear and unused requests through the request channel,
// predicts every result from a screen model kept in the bench, and compares
// each result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_text_console_cursor_scroll_unit;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROWS = 25;
   localparam int COLS = 80;

   // The unused request code is not part of the package.
   localparam logic [tccs_pkg::TYPE_W-1:0] REQ_UNUSED = 2'd3;

   // Worst case: every one of about 1375 requests walks the screen for a
   // scroll, plus sender gaps and receiver stalls, on top of the clearing
   // sweep after reset; the limit is about three times that.
   localparam int LIMIT_CYCLES = 9_000_000;
   localparam int HOLD_CYCLES  = 200;
   localparam int CHUNK_ITEMS  = 150;
   localparam int MAX_PRINTED  = 40;

   typedef struct packed {
      logic [tccs_pkg::TYPE_W-1:0] kind;
      logic [tccs_pkg::CHAR_W-1:0] code;
      logic [tccs_pkg::ROW_W-1:0]  row;
      logic [tccs_pkg::COL_W-1:0]  col;
   } console_req_type;

   // Clock, reset and ports.
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [tccs_pkg::TYPE_W-1:0] req_type = '0;
   logic [tccs_pkg::CHAR_W-1:0] req_char_code = '0;
   logic [tccs_pkg::ROW_W-1:0]  req_read_row = '0;
   logic [tccs_pkg::COL_W-1:0]  req_read_col = '0;

   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [tccs_pkg::CHAR_W-1:0] rsp_cell_char;
   logic [tccs_pkg::CHAR_W-1:0] rsp_cell_attr;
   logic [tccs_pkg::ROW_W-1:0]  rsp_cursor_row;
   logic [tccs_pkg::COL_W-1:0]  rsp_cursor_col;

   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [tccs_pkg::CHAR_W-1:0] csr_text_attribute = '0;

   // Screen model and cursor kept by the bench.
   logic [tccs_pkg::CELL_W-1:0] screen_model [ROWS*COLS];
   int                          model_row = 0;
   int                          model_col = 0;
   logic [tccs_pkg::CHAR_W-1:0] model_attr = tccs_pkg::ATTR_RESET;

   console_req_type   pending_req [$];
   tccs_pkg::rsp_type expected_rsp [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_wanted = 1'b0;
   bit hold_done = 1'b0;
   int hold_count = 0;
   int error_count = 0;
   int cycle_count = 0;

   text_console_cursor_scroll_unit #(
      .ROWS(ROWS),
      .COLS(COLS)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_char_code      (req_char_code),
      .req_read_row       (req_read_row),
      .req_read_col       (req_read_col),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_cell_char      (rsp_cell_char),
      .rsp_cell_attr      (rsp_cell_attr),
      .rsp_cursor_row     (rsp_cursor_row),
      .rsp_cursor_col     (rsp_cursor_col),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_text_attribute (csr_text_attribute)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Prints one line per failure, up to a cap, and counts every one.
   task automatic report_error(input string msg);
      if (error_count < MAX_PRINTED) begin
         $display("ERROR @%0t: %s", $time, msg);
      end
      error_count++;
   endtask

   // Applies one request to the screen model and returns its result.
   function automatic tccs_pkg::rsp_type predict_console(input console_req_type rq);
      tccs_pkg::rsp_type res;
      int                pos;
      res = '0;
      case (rq.kind)
         tccs_pkg::REQ_PUT: begin
            // A pending scroll is resolved before the character is handled.
            if (model_row >= ROWS) begin
               for (int i = 0; i < (ROWS - 1) * COLS; i++) begin
                  screen_model[i] = screen_model[i + COLS];
               end
               for (int i = (ROWS - 1) * COLS; i < ROWS * COLS; i++) begin
                  screen_model[i] = '0;
               end
               model_row = ROWS - 1;
            end
            if (rq.code == tccs_pkg::CH_NEWLINE) begin
               model_row++;
               model_col = 0;
            end else if (rq.code == tccs_pkg::CH_RETURN) begin
               model_col = 0;
            end else begin
               pos = model_row * COLS + model_col;
               if (pos < ROWS * COLS) begin
                  screen_model[pos] = {model_attr, rq.code};
               end
               model_col++;
               if (model_col >= COLS) begin
                  model_row++;
                  model_col = 0;
               end
            end
         end
         tccs_pkg::REQ_READ: begin
            // Reads outside the screen return a zero cell.
            if (rq.row < ROWS && rq.col < COLS) begin
               {res.cell_attr, res.cell_char} = screen_model[rq.row * COLS + rq.col];
            end
         end
         tccs_pkg::REQ_CLEAR: begin
            foreach (screen_model[i]) begin
               screen_model[i] = '0;
            end
         end
         default: begin
         end
      endcase
      res.cursor_row = tccs_pkg::ROW_W'(model_row);
      res.cursor_col = tccs_pkg::COL_W'(model_col);
      return res;
   endfunction

   function automatic console_req_type make_req(input logic [tccs_pkg::TYPE_W-1:0] kind,
                                                input int code, input int row,
                                                input int col);
      console_req_type rq;
      rq.kind = kind;
      rq.code = tccs_pkg::CHAR_W'(code);
      rq.row  = tccs_pkg::ROW_W'(row);
      rq.col  = tccs_pkg::COL_W'(col);
      return rq;
   endfunction

   // Random request: mostly puts and reads near the bottom rows, where
   // the cursor spends most of its time, with rare clears and unused requests.
   function automatic console_req_type random_req();
      console_req_type rq;
      int              pick;
      rq.code = tccs_pkg::CHAR_W'($urandom_range(255, 0));
      rq.row  = tccs_pkg::ROW_W'($urandom_range(31, 0));
      rq.col  = tccs_pkg::COL_W'($urandom_range(127, 0));
      pick = $urandom_range(99, 0);
      if (pick < 58) begin
         rq.kind = tccs_pkg::REQ_PUT;
         pick = $urandom_range(99, 0);
         if (pick < 8) begin
            rq.code = tccs_pkg::CH_NEWLINE;
         end else if (pick < 12) begin
            rq.code = tccs_pkg::CH_RETURN;
         end
      end else if (pick < 93) begin
         rq.kind = tccs_pkg::REQ_READ;
         pick = $urandom_range(99, 0);
         if (pick < 50) begin
            rq.row = tccs_pkg::ROW_W'($urandom_range(ROWS - 1, ROWS - 5));
            rq.col = tccs_pkg::COL_W'($urandom_range(COLS - 1, 0));
         end else if (pick < 80) begin
            rq.row = tccs_pkg::ROW_W'($urandom_range(ROWS - 1, 0));
            rq.col = tccs_pkg::COL_W'($urandom_range(COLS - 1, 0));
         end
      end else if (pick < 96) begin
         rq.kind = tccs_pkg::REQ_CLEAR;
      end else begin
         rq.kind = REQ_UNUSED;
      end
      return rq;
   endfunction

   // Waits until every queued request has been transferred and answered.
   task automatic wait_drained();
      while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Writes the attribute register; only called while the unit is idle.
   task automatic write_attribute(input logic [tccs_pkg::CHAR_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_text_attribute <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      model_attr = value;
      csr_valid <= 1'b0;
   endtask

   // Random requests in chunks; the sender pauses after each chunk until
   // every expected result has come back.
   task automatic run_random(input int count);
      int left;
      left = count;
      while (left > 0) begin
         for (int i = 0; i < CHUNK_ITEMS && i < left; i++) begin
            pending_req.push_back(random_req());
         end
         left -= CHUNK_ITEMS;
         wait_drained();
      end
   endtask

   // Request driver: fed from the pending queue, predicts at each transfer.
   always @(posedge clock) begin : req_driver
      console_req_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsp.push_back(predict_console({req_type, req_char_code,
                                                    req_read_row, req_read_col}));
         end
         if (!req_valid || req_ready) begin
            if (pending_req.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               next_req = pending_req.pop_front();
               req_valid <= 1'b1;
               req_type <= next_req.kind;
               req_char_code <= next_req.code;
               req_read_row <= next_req.row;
               req_read_col <= next_req.col;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result receiver: random stalls, plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_wanted && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_count <= hold_count + 1;
         if (hold_count == HOLD_CYCLES - 1) begin
            hold_done <= 1'b1;
         end
      end else begin
         rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   // Result monitor: each transfer is checked against the oldest prediction.
   always @(posedge clock) begin : rsp_monitor
      tccs_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            report_error("result transfer with no result expected");
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_cell_char !== want.cell_char) begin
               report_error($sformatf("cell_char got %0h want %0h",
                                      rsp_cell_char, want.cell_char));
            end
            if (rsp_cell_attr !== want.cell_attr) begin
               report_error($sformatf("cell_attr got %0h want %0h",
                                      rsp_cell_attr, want.cell_attr));
            end
            if (rsp_cursor_row !== want.cursor_row) begin
               report_error($sformatf("cursor_row got %0d want %0d",
                                      rsp_cursor_row, want.cursor_row));
            end
            if (rsp_cursor_col !== want.cursor_col) begin
               report_error($sformatf("cursor_col got %0d want %0d",
                                      rsp_cursor_col, want.cursor_col));
            end
         end
      end
   end

   // Watchdog on a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("tb_text_console_cursor_scroll_unit: errors");
         $finish;
      end
   end

   initial begin : stimulus
      foreach (screen_model[i]) begin
         screen_model[i] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Sender idles lightly, receiver heavily; attribute at its reset value.
      send_idle_pct = 27;
      recv_idle_pct = 74;
      pending_req.push_back(make_req(tccs_pkg::REQ_READ, 8'h00, 0, 0));
      pending_req.push_back(make_req(tccs_pkg::REQ_PUT, 8'h41, 31, 127));
      pending_req.push_back(make_req(tccs_pkg::REQ_READ, 8'hFF, 0, 0));
      pending_req.push_back(make_req(tccs_pkg::REQ_PUT, 8'hFF, 0, 0));
      pending_req.push_back(make_req(tccs_pkg::REQ_PUT, 8'h00, 0, 0));
      pending_req.push_back(make_req(tccs_pkg::REQ_READ, 8'h00, 0, 1));
      pending_req.push_back(make_req(tccs_pkg::REQ_READ, 8'h00, 0, 2));
      pending_req.push_back(make_req(tccs_pkg::REQ_PUT, tccs_pkg::CH_RETURN, 0, 0));
      pending_req.push_back(make_req(tccs_pkg::REQ_PUT, tccs_pkg::CH_NEWLINE, 0, 0));
      // Reads outside the screen in row, in column, and in both.
      pending_req.push_back(make_req(tccs_pkg::REQ_READ, 8'h00, 31, 127));
      pending_req.push_back(make_req(tccs_pkg::REQ_READ, 8'h00, 0, COLS));
      pending_req.push_back(make_req(tccs_pkg::REQ_READ, 8'h00, ROWS, 0));
      pending_req.push_back(make_req(REQ_UNUSED, 8'hA5, 17, 99));
      pending_req.push_back(make_req(tccs_pkg::REQ_PUT, 8'h7E, 0, 0));
      pending_req.push_back(make_req(tccs_pkg::REQ_CLEAR, 8'h5A, 10, 10));
      pending_req.push_back(make_req(tccs_pkg::REQ_READ, 8'h00, 0, 0));
      pending_req.push_back(make_req(tccs_pkg::REQ_READ, 8'h00, 1, 0));
      wait_drained();

      write_attribute(8'hFF);
      run_random(450);

      // Receiver idles lightly, sender heavily; attribute at zero.
      send_idle_pct = 74;
      recv_idle_pct = 27;
      write_attribute(8'h00);
      // Walk the cursor down to a pending scroll, then exercise it.
      for (int i = model_row; i < ROWS; i++) begin
         pending_req.push_back(make_req(tccs_pkg::REQ_PUT, tccs_pkg::CH_NEWLINE, 0, 0));
      end
      pending_req.push_back(make_req(tccs_pkg::REQ_READ, 8'h00, ROWS, 0));
      pending_req.push_back(make_req(tccs_pkg::REQ_READ, 8'h00, ROWS - 1, 0));
      pending_req.push_back(make_req(tccs_pkg::REQ_CLEAR, 8'h00, 0, 0));
      pending_req.push_back(make_req(tccs_pkg::REQ_PUT, 8'h78, 0, 0));
      pending_req.push_back(make_req(tccs_pkg::REQ_READ, 8'h00, ROWS - 1, 0));
      pending_req.push_back(make_req(tccs_pkg::REQ_READ, 8'h00, ROWS - 2, 0));
      pending_req.push_back(make_req(tccs_pkg::REQ_PUT, tccs_pkg::CH_RETURN, 0, 0));
      // Newline on the last row leaves a pending scroll behind.
      pending_req.push_back(make_req(tccs_pkg::REQ_PUT, tccs_pkg::CH_NEWLINE, 0, 0));
      pending_req.push_back(make_req(tccs_pkg::REQ_PUT, tccs_pkg::CH_NEWLINE, 0, 0));
      pending_req.push_back(make_req(tccs_pkg::REQ_READ, 8'h00, ROWS - 3, 0));
      pending_req.push_back(make_req(REQ_UNUSED, 8'h00, 0, 0));
      wait_drained();
      run_random(450);

      // No idling; the receiver first holds off long enough to stall input.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_attribute(8'($urandom_range(254, 1)));
      hold_wanted = 1'b1;
      run_random(450);

      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_text_console_cursor_scroll_unit: clean");
      end else begin
         $display("tb_text_console_cursor_scroll_unit: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/tccs_pkg.sv
rtl/core/tccs_ram.sv
rtl/core/tccs_seq.sv
rtl/core/text_console_cursor_scroll_unit.sv
tb/tb_text_console_cursor_scroll_unit.sv
